// ===== hw/rtl/dll_pkg.sv =====
// Shared types and constants for the doubly linked list engine.
// Used by dll_ctrl, dll_dp and the top level; depends on nothing else.
package dll_pkg;

    localparam int DATA_W        = 32;
    localparam int MODE_W        = 5;
    localparam int ERR_W         = 2;
    localparam int IN_TDATA_W    = 40;
    localparam int OUT_TDATA_W   = 40;
    localparam int OUT_PAD_W     = OUT_TDATA_W - DATA_W - ERR_W - 1;
    localparam int DEF_POOL_SIZE = 64;

    // Command codes carried in the mode field.
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 5'd0;
    localparam logic [MODE_W-1:0] MODE_INS_HEAD   = 5'd1;
    localparam logic [MODE_W-1:0] MODE_INS_TAIL   = 5'd2;
    localparam logic [MODE_W-1:0] MODE_CUR_FIRST  = 5'd3;
    localparam logic [MODE_W-1:0] MODE_CUR_LAST   = 5'd4;
    localparam logic [MODE_W-1:0] MODE_READ_HEAD  = 5'd5;
    localparam logic [MODE_W-1:0] MODE_READ_TAIL  = 5'd6;
    localparam logic [MODE_W-1:0] MODE_DEL_HEAD   = 5'd7;
    localparam logic [MODE_W-1:0] MODE_DEL_TAIL   = 5'd8;
    localparam logic [MODE_W-1:0] MODE_DEL_AFTER  = 5'd9;
    localparam logic [MODE_W-1:0] MODE_DEL_BEFORE = 5'd10;
    localparam logic [MODE_W-1:0] MODE_INS_AFTER  = 5'd11;
    localparam logic [MODE_W-1:0] MODE_INS_BEFORE = 5'd12;
    localparam logic [MODE_W-1:0] MODE_READ_CUR   = 5'd13;
    localparam logic [MODE_W-1:0] MODE_WRITE_CUR  = 5'd14;
    localparam logic [MODE_W-1:0] MODE_NEXT       = 5'd15;
    localparam logic [MODE_W-1:0] MODE_PREV       = 5'd16;

    // Result error codes.
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

    // Datapath operations, one per clock cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_CUR_END,
        OP_WRITE_CUR,
        OP_STEP_RD,
        OP_STEP,
        OP_VAL_RD,
        OP_DEL_END_RD,
        OP_DEL_END_FIN,
        OP_DEL_NB_RD,
        OP_DEL_NB_T,
        OP_DEL_NB_FIN,
        OP_INS_RD,
        OP_INS_LINK,
        OP_INS_FIN
    } dll_op_t;

    // fwd selects the forward direction (head side, next links);
    // at_cur selects the cursor as anchor instead of a list end.
    typedef struct packed {
        dll_op_t          op;
        logic             fwd;
        logic             at_cur;
        logic [ERR_W-1:0] err;
        logic             rd_sel;
    } dll_cmd_t;

    typedef struct packed {
        logic head_ok;
        logic cur_ok;
        logic cur_is_head;
        logic cur_is_tail;
        logic one_node;
        logic can_take;
        logic t_is_end;
    } dll_status_t;

    localparam dll_cmd_t CMD_IDLE = '{
        op:     OP_NONE,
        fwd:    1'b0,
        at_cur: 1'b0,
        err:    ERR_OK,
        rd_sel: 1'b0
    };

endpackage

// ===== hw/rtl/dll_ctrl.sv =====
// Command sequencer for the doubly linked list engine.
// Depends on dll_pkg; drives dll_dp through dll_cmd_t and reads dll_status_t.
module dll_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    output logic                          in_load,
    input  logic [dll_pkg::MODE_W-1:0]    mode,
    input  dll_pkg::dll_status_t          status,
    output dll_pkg::dll_cmd_t             cmd,
    output logic                          out_load,
    output logic                          out_valid,
    input  logic                          out_ready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    dll_pkg::dll_cmd_t cmd_reg;
    dll_pkg::dll_cmd_t cmd_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign in_load  = in_ready && in_valid;
    assign out_load = (state_reg == S_DONE) && out_free;
    assign cmd      = cmd_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = dll_pkg::CMD_IDLE;
                    state_next = S_EXEC;
                    unique case (mode) inside
                        dll_pkg::MODE_CLEAR:
                        begin
                            cmd_next.op = dll_pkg::OP_CLEAR;
                        end
                        dll_pkg::MODE_INS_HEAD, dll_pkg::MODE_INS_TAIL:
                        begin
                            cmd_next.fwd = (mode == dll_pkg::MODE_INS_HEAD);
                            if (status.can_take)
                            begin
                                cmd_next.op = dll_pkg::OP_INS_RD;
                            end
                            else
                            begin
                                cmd_next.err = dll_pkg::ERR_FULL;
                                state_next   = S_DONE;
                            end
                        end
                        dll_pkg::MODE_CUR_FIRST, dll_pkg::MODE_CUR_LAST:
                        begin
                            cmd_next.fwd = (mode == dll_pkg::MODE_CUR_FIRST);
                            cmd_next.op  = dll_pkg::OP_CUR_END;
                        end
                        dll_pkg::MODE_READ_HEAD, dll_pkg::MODE_READ_TAIL:
                        begin
                            cmd_next.fwd = (mode == dll_pkg::MODE_READ_HEAD);
                            if (status.head_ok)
                            begin
                                cmd_next.op     = dll_pkg::OP_VAL_RD;
                                cmd_next.rd_sel = 1'b1;
                            end
                            else
                            begin
                                cmd_next.err = dll_pkg::ERR_EMPTY;
                                state_next   = S_DONE;
                            end
                        end
                        dll_pkg::MODE_DEL_HEAD, dll_pkg::MODE_DEL_TAIL:
                        begin
                            cmd_next.fwd = (mode == dll_pkg::MODE_DEL_HEAD);
                            if (status.head_ok)
                            begin
                                cmd_next.op = dll_pkg::OP_DEL_END_RD;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        dll_pkg::MODE_DEL_AFTER:
                        begin
                            cmd_next.fwd = 1'b1;
                            if (status.cur_ok && !status.cur_is_tail)
                            begin
                                cmd_next.op = dll_pkg::OP_DEL_NB_RD;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        dll_pkg::MODE_DEL_BEFORE:
                        begin
                            if (status.cur_ok && !status.cur_is_head)
                            begin
                                cmd_next.op = dll_pkg::OP_DEL_NB_RD;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        dll_pkg::MODE_INS_AFTER, dll_pkg::MODE_INS_BEFORE:
                        begin
                            cmd_next.fwd    = (mode == dll_pkg::MODE_INS_AFTER);
                            cmd_next.at_cur = 1'b1;
                            if (!status.cur_ok)
                            begin
                                state_next = S_DONE;
                            end
                            else if (!status.can_take)
                            begin
                                cmd_next.err = dll_pkg::ERR_FULL;
                                state_next   = S_DONE;
                            end
                            else
                            begin
                                cmd_next.op = dll_pkg::OP_INS_RD;
                            end
                        end
                        dll_pkg::MODE_READ_CUR:
                        begin
                            cmd_next.at_cur = 1'b1;
                            if (status.cur_ok)
                            begin
                                cmd_next.op     = dll_pkg::OP_VAL_RD;
                                cmd_next.rd_sel = 1'b1;
                            end
                            else
                            begin
                                cmd_next.err = dll_pkg::ERR_EMPTY;
                                state_next   = S_DONE;
                            end
                        end
                        dll_pkg::MODE_WRITE_CUR:
                        begin
                            cmd_next.op = dll_pkg::OP_WRITE_CUR;
                        end
                        dll_pkg::MODE_NEXT, dll_pkg::MODE_PREV:
                        begin
                            cmd_next.fwd = (mode == dll_pkg::MODE_NEXT);
                            if (status.cur_ok)
                            begin
                                cmd_next.op = dll_pkg::OP_STEP_RD;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_EXEC:
            begin
                cmd_next.op = dll_pkg::OP_NONE;
                state_next  = S_DONE;
                unique case (cmd_reg.op)
                    dll_pkg::OP_STEP_RD:
                    begin
                        cmd_next.op = dll_pkg::OP_STEP;
                        state_next  = S_EXEC;
                    end
                    dll_pkg::OP_DEL_END_RD:
                    begin
                        if (!status.one_node)
                        begin
                            cmd_next.op = dll_pkg::OP_DEL_END_FIN;
                            state_next  = S_EXEC;
                        end
                    end
                    dll_pkg::OP_DEL_NB_RD:
                    begin
                        cmd_next.op = dll_pkg::OP_DEL_NB_T;
                        state_next  = S_EXEC;
                    end
                    dll_pkg::OP_DEL_NB_T:
                    begin
                        if (!status.t_is_end)
                        begin
                            cmd_next.op = dll_pkg::OP_DEL_NB_FIN;
                            state_next  = S_EXEC;
                        end
                    end
                    dll_pkg::OP_INS_RD:
                    begin
                        cmd_next.op = dll_pkg::OP_INS_LINK;
                        state_next  = S_EXEC;
                    end
                    dll_pkg::OP_INS_LINK:
                    begin
                        cmd_next.op = dll_pkg::OP_INS_FIN;
                        state_next  = S_EXEC;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= dll_pkg::CMD_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/dll_dp.sv =====
// Datapath of the doubly linked list engine: node pool memories, free stack,
// list pointers and the result register. Depends on dll_pkg; driven by dll_ctrl.
module dll_dp #(
    parameter int POOL_SIZE = dll_pkg::DEF_POOL_SIZE
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  dll_pkg::dll_cmd_t                  cmd,
    input  logic                               in_load,
    input  logic signed [dll_pkg::DATA_W-1:0]  in_value,
    input  logic                               out_load,
    output dll_pkg::dll_status_t               status,
    output logic signed [dll_pkg::DATA_W-1:0]  read_value,
    output logic [dll_pkg::ERR_W-1:0]          error_code,
    output logic                               cursor_active
);

    localparam int IW = $clog2(POOL_SIZE);
    localparam int PW = $clog2(POOL_SIZE + 1);
    localparam logic [PW-1:0] NIL = PW'(POOL_SIZE);

    function automatic logic is_node(input logic [PW-1:0] p);
        return p < NIL;
    endfunction

    logic signed [dll_pkg::DATA_W-1:0] value_mem [POOL_SIZE];
    logic [PW-1:0]                     next_mem  [POOL_SIZE];
    logic [PW-1:0]                     prev_mem  [POOL_SIZE];
    logic [IW-1:0]                     free_mem  [POOL_SIZE];

    logic signed [dll_pkg::DATA_W-1:0] value_rd_reg;
    logic [PW-1:0]                     next_rd_reg;
    logic [PW-1:0]                     prev_rd_reg;
    logic [IW-1:0]                     free_rd_reg;

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [PW-1:0] cur_reg, cur_next;
    logic [PW-1:0] free_top_reg, free_top_next;
    logic [PW-1:0] fresh_reg, fresh_next;
    logic [PW-1:0] t_reg, t_next;
    logic [PW-1:0] n_reg, n_next;

    logic signed [dll_pkg::DATA_W-1:0] value_in_reg;
    logic signed [dll_pkg::DATA_W-1:0] out_value_reg;
    logic [dll_pkg::ERR_W-1:0]         out_err_reg;
    logic                              out_cur_reg;

    logic                              vw_en, nw_en, pw_en, fw_en;
    logic [PW-1:0]                     vw_idx, nw_idx, pw_idx;
    logic signed [dll_pkg::DATA_W-1:0] vw_data;
    logic [PW-1:0]                     nw_data, pw_data;
    logic                              vr_en, nr_en, pr_en, fr_en;
    logic [PW-1:0]                     vr_idx, nr_idx, pr_idx;

    logic [PW-1:0] free_top_dec;
    logic [PW-1:0] end_node;
    logic [PW-1:0] nb_rd;
    logic          nb_is_end;
    logic [PW-1:0] take_idx;
    logic [PW-1:0] ins_t;
    logic [PW-1:0] anchor;
    logic          push_en;
    logic [PW-1:0] push_idx;

    // Helpers shared by several operations.
    assign free_top_dec = free_top_reg - PW'(1);
    assign end_node     = cmd.fwd ? head_reg : tail_reg;
    assign nb_rd        = cmd.fwd ? next_rd_reg : prev_rd_reg;
    assign nb_is_end    = cmd.fwd ? (next_rd_reg == tail_reg) : (prev_rd_reg == head_reg);
    assign take_idx     = (free_top_reg != '0) ? PW'(free_rd_reg) : fresh_reg;
    assign ins_t        = cmd.at_cur ? nb_rd : end_node;
    assign anchor       = cmd.at_cur ? cur_reg : NIL;

    assign status.head_ok     = is_node(head_reg);
    assign status.cur_ok      = is_node(cur_reg);
    assign status.cur_is_head = (cur_reg == head_reg);
    assign status.cur_is_tail = (cur_reg == tail_reg);
    assign status.one_node    = (head_reg == tail_reg);
    assign status.can_take    = (free_top_reg != '0) || (fresh_reg < NIL);
    assign status.t_is_end    = nb_is_end;

    // Read ports: the link memories are read at the cursor unless a list end
    // or the node just fetched has to be followed.
    always_comb
    begin
        nr_en  = 1'b0;
        pr_en  = 1'b0;
        nr_idx = cur_reg;
        pr_idx = cur_reg;
        case (cmd.op) inside
            dll_pkg::OP_STEP_RD, dll_pkg::OP_DEL_NB_RD, dll_pkg::OP_INS_RD:
            begin
                nr_en = 1'b1;
                pr_en = 1'b1;
            end
            dll_pkg::OP_DEL_END_RD:
            begin
                nr_en  = 1'b1;
                pr_en  = 1'b1;
                nr_idx = head_reg;
                pr_idx = tail_reg;
            end
            dll_pkg::OP_DEL_NB_T:
            begin
                nr_en  = 1'b1;
                pr_en  = 1'b1;
                nr_idx = next_rd_reg;
                pr_idx = prev_rd_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign vr_en  = (cmd.op == dll_pkg::OP_VAL_RD);
    assign vr_idx = cmd.at_cur ? cur_reg : end_node;
    assign fr_en  = (cmd.op == dll_pkg::OP_INS_RD) && (free_top_reg != '0);

    // State updates and write ports. Each memory takes at most one write per op.
    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        cur_next      = cur_reg;
        free_top_next = free_top_reg;
        fresh_next    = fresh_reg;
        t_next        = t_reg;
        n_next        = n_reg;
        vw_en         = 1'b0;
        vw_idx        = cur_reg;
        vw_data       = value_in_reg;
        nw_en         = 1'b0;
        nw_idx        = cur_reg;
        nw_data       = NIL;
        pw_en         = 1'b0;
        pw_idx        = cur_reg;
        pw_data       = NIL;
        fw_en         = 1'b0;
        push_en       = 1'b0;
        push_idx      = t_reg;

        case (cmd.op)
            dll_pkg::OP_CLEAR:
            begin
                head_next     = NIL;
                tail_next     = NIL;
                cur_next      = NIL;
                free_top_next = '0;
                fresh_next    = '0;
            end
            dll_pkg::OP_CUR_END:
            begin
                cur_next = end_node;
            end
            dll_pkg::OP_WRITE_CUR:
            begin
                vw_en = is_node(cur_reg);
            end
            dll_pkg::OP_STEP:
            begin
                cur_next = nb_rd;
            end
            dll_pkg::OP_DEL_END_RD:
            begin
                t_next = end_node;
                if (cur_reg == end_node)
                begin
                    cur_next = NIL;
                end
                if (head_reg == tail_reg)
                begin
                    head_next = NIL;
                    tail_next = NIL;
                    push_en   = 1'b1;
                    push_idx  = end_node;
                end
            end
            dll_pkg::OP_DEL_END_FIN:
            begin
                push_en = 1'b1;
                if (cmd.fwd)
                begin
                    head_next = next_rd_reg;
                    pw_en     = is_node(next_rd_reg);
                    pw_idx    = next_rd_reg;
                end
                else
                begin
                    tail_next = prev_rd_reg;
                    nw_en     = is_node(prev_rd_reg);
                    nw_idx    = prev_rd_reg;
                end
            end
            dll_pkg::OP_DEL_NB_T:
            begin
                t_next = nb_rd;
                if (nb_is_end)
                begin
                    push_en  = 1'b1;
                    push_idx = nb_rd;
                    if (cmd.fwd)
                    begin
                        nw_en     = 1'b1;
                        tail_next = cur_reg;
                    end
                    else
                    begin
                        pw_en     = 1'b1;
                        head_next = cur_reg;
                    end
                end
            end
            dll_pkg::OP_DEL_NB_FIN:
            begin
                push_en = 1'b1;
                if (cmd.fwd)
                begin
                    pw_en   = is_node(nb_rd);
                    pw_idx  = nb_rd;
                    pw_data = cur_reg;
                    nw_en   = 1'b1;
                    nw_data = nb_rd;
                end
                else
                begin
                    nw_en   = is_node(nb_rd);
                    nw_idx  = nb_rd;
                    nw_data = cur_reg;
                    pw_en   = 1'b1;
                    pw_data = nb_rd;
                end
            end
            dll_pkg::OP_INS_LINK:
            begin
                n_next = take_idx;
                if (free_top_reg != '0)
                begin
                    free_top_next = free_top_dec;
                end
                else
                begin
                    fresh_next = fresh_reg + PW'(1);
                end
                vw_en  = 1'b1;
                vw_idx = take_idx;
                if (cmd.fwd)
                begin
                    nw_en   = 1'b1;
                    nw_idx  = take_idx;
                    nw_data = ins_t;
                    if (is_node(ins_t))
                    begin
                        pw_en   = 1'b1;
                        pw_idx  = ins_t;
                        pw_data = take_idx;
                    end
                    else
                    begin
                        tail_next = take_idx;
                    end
                end
                else
                begin
                    pw_en   = 1'b1;
                    pw_idx  = take_idx;
                    pw_data = ins_t;
                    if (is_node(ins_t))
                    begin
                        nw_en   = 1'b1;
                        nw_idx  = ins_t;
                        nw_data = take_idx;
                    end
                    else
                    begin
                        head_next = take_idx;
                    end
                end
            end
            dll_pkg::OP_INS_FIN:
            begin
                if (cmd.fwd)
                begin
                    pw_en   = 1'b1;
                    pw_idx  = n_reg;
                    pw_data = anchor;
                    if (is_node(anchor))
                    begin
                        nw_en   = 1'b1;
                        nw_idx  = anchor;
                        nw_data = n_reg;
                    end
                    else
                    begin
                        head_next = n_reg;
                    end
                end
                else
                begin
                    nw_en   = 1'b1;
                    nw_idx  = n_reg;
                    nw_data = anchor;
                    if (is_node(anchor))
                    begin
                        pw_en   = 1'b1;
                        pw_idx  = anchor;
                        pw_data = n_reg;
                    end
                    else
                    begin
                        tail_next = n_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // A freed node goes back on the free stack.
        if (push_en && is_node(push_idx) && (free_top_reg < NIL))
        begin
            fw_en         = 1'b1;
            free_top_next = free_top_reg + PW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (vw_en)
        begin
            value_mem[vw_idx[IW-1:0]] <= vw_data;
        end
        if (vr_en)
        begin
            value_rd_reg <= value_mem[vr_idx[IW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (nw_en)
        begin
            next_mem[nw_idx[IW-1:0]] <= nw_data;
        end
        if (nr_en)
        begin
            next_rd_reg <= next_mem[nr_idx[IW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pw_en)
        begin
            prev_mem[pw_idx[IW-1:0]] <= pw_data;
        end
        if (pr_en)
        begin
            prev_rd_reg <= prev_mem[pr_idx[IW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fw_en)
        begin
            free_mem[free_top_reg[IW-1:0]] <= push_idx[IW-1:0];
        end
        if (fr_en)
        begin
            free_rd_reg <= free_mem[free_top_dec[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= NIL;
            tail_reg     <= NIL;
            cur_reg      <= NIL;
            free_top_reg <= '0;
            fresh_reg    <= '0;
        end
        else
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            cur_reg      <= cur_next;
            free_top_reg <= free_top_next;
            fresh_reg    <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
        n_reg <= n_next;
        if (in_load)
        begin
            value_in_reg <= in_value;
        end
        if (out_load)
        begin
            out_value_reg <= cmd.rd_sel ? value_rd_reg : '0;
            out_err_reg   <= cmd.err;
            out_cur_reg   <= is_node(cur_reg);
        end
    end

    assign read_value    = out_value_reg;
    assign error_code    = out_err_reg;
    assign cursor_active = out_cur_reg;

endmodule

// ===== hw/rtl/doubly_linked_list_with_cursor.sv =====
// Top level of the doubly linked list engine with cursor.
// Depends on dll_pkg, dll_ctrl (sequencer) and dll_dp (pool memories and pointers).

// The block keeps signed 32-bit values in a pool of POOL_SIZE nodes chained
// forward and backward, with a head, a tail and a cursor, and executes one
// command per input request, answering every request with exactly one result
// request. Commands are taken one at a time: between acceptance and result
// hand-over a request runs a chain of datapath operations set by the dependent
// link reads through the registered read ports of the link memories. A command
// whose precondition fails (empty list, no cursor, full pool) and an unused
// code run no operation, except an overwrite, which runs with or without a
// cursor. The result sits in an output register, so the next command is
// accepted while a finished result waits to be taken; a command only stalls
// when its own result is ready and the previous one still has not been
// collected. Clearing is immediate, there is no clearing pass after reset, and
// a read only ever returns the value of a node that has been written.
module doubly_linked_list_with_cursor #(
    parameter int POOL_SIZE = dll_pkg::DEF_POOL_SIZE
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dll_pkg::IN_TDATA_W-1:0]      s_tdata,   // mode[4:0], value[36:5]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dll_pkg::OUT_TDATA_W-1:0]     m_tdata    // read_value[31:0],
                                                           // error_code[33:32],
                                                           // cursor_active[34]
);

    logic [dll_pkg::MODE_W-1:0]         mode;
    logic signed [dll_pkg::DATA_W-1:0]  value;
    logic signed [dll_pkg::DATA_W-1:0]  read_value;
    logic [dll_pkg::ERR_W-1:0]          error_code;
    logic                               cursor_active;
    logic                               in_load;
    logic                               out_load;
    dll_pkg::dll_cmd_t                  cmd;
    dll_pkg::dll_status_t               status;

    // Unpack the incoming request.
    assign mode  = s_tdata[dll_pkg::MODE_W-1:0];
    assign value = s_tdata[dll_pkg::MODE_W +: dll_pkg::DATA_W];

    // The sequencer decodes each command against the list status and steps
    // the datapath one operation per cycle.
    dll_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_load   (in_load),
        .mode      (mode),
        .status    (status),
        .cmd       (cmd),
        .out_load  (out_load),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

    // The datapath owns the node pool, the free stack and the result register.
    dll_dp #(
        .POOL_SIZE (POOL_SIZE)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .in_load       (in_load),
        .in_value      (value),
        .out_load      (out_load),
        .status        (status),
        .read_value    (read_value),
        .error_code    (error_code),
        .cursor_active (cursor_active)
    );

    // Pack the result request, padded with zeros to whole bytes.
    assign m_tdata = {{dll_pkg::OUT_PAD_W{1'b0}}, cursor_active, error_code, read_value};

`ifndef SYNTH
    // Only one command is ever in progress.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a command was still in progress");

    // A result is only loaded when the output register is free or being emptied.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_tvalid || m_tready))
        else $error("result register overwritten before it was taken");

    // A failed command never reports a read value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (error_code != dll_pkg::ERR_OK)) |-> (read_value == '0))
        else $error("error result carries a non-zero read value");

    // Only defined error codes appear on the result.
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((error_code == dll_pkg::ERR_OK) || (error_code == dll_pkg::ERR_EMPTY)
                      || (error_code == dll_pkg::ERR_FULL)))
        else $error("undefined error code on result");
`endif

endmodule
